// File: src/eps_pkg.sv
`timescale 1ns / 1ps
// Package for the envelope peak stretcher: shared constants, transaction types,
// sequencer control structs and small helper functions.
// Depends on nothing; every other file in src imports it.
package eps_pkg;

    // Sample format and look-ahead depth.
    localparam int SW        = 16;
    localparam int LOOKAHEAD = 2;
    localparam int HIST_LEN  = 2 * LOOKAHEAD;

    // Derived widths of the datapath.
    localparam int ABS_W  = SW + 1;
    localparam int SUM_W  = 2 * SW;
    localparam int REM_W  = SW + 4;
    localparam int CNT_W  = $clog2(SW);

    // Shared multiplier operand and product widths.
    localparam int MUL_W  = 19;
    localparam int PROD_W = 2 * MUL_W;

    // Gain in unsigned Q4.12; 2*emax = 4*sqrt(2) scaled by 2^16.
    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 12;
    localparam int DIV_SHIFT = SW - GAIN_FRAC;
    localparam int G_LSB     = SW + 3;
    localparam logic [MUL_W-1:0]  TWO_EMAX_K = MUL_W'(370728);
    localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(4096);
    localparam logic [GAIN_W-1:0] GAIN_TWO   = GAIN_W'(8192);

    typedef logic [CNT_W-1:0] cnt_t;

    // Payload of one input transaction.
    typedef struct packed {
        logic signed [SW-1:0] in_i;
        logic signed [SW-1:0] in_q;
    } in_item_t;

    // Payload of one output transaction.
    typedef struct packed {
        logic signed [SW-1:0] out_i;
        logic signed [SW-1:0] out_q;
    } out_item_t;

    // Requests from the interface logic to the sequencer.
    typedef struct packed {
        logic start;
        logic ack;
    } seq_ctrl_t;

    // Status from the sequencer back to the interface logic.
    typedef struct packed {
        logic busy;
        logic done;
    } seq_stat_t;

    // Magnitude of a signed sample, one bit wider so that the most negative value fits.
    function automatic logic [ABS_W-1:0] abs_val(input logic signed [SW-1:0] v);
        logic [ABS_W-1:0] ext;
        ext = {v[SW-1], v};
        return v[SW-1] ? (~ext + 1'b1) : ext;
    endfunction

endpackage

// File: src/eps_mult.sv
`timescale 1ns / 1ps
// Shared unsigned multiplier of the envelope peak stretcher, used for both squares
// and for the gain product. Depends on eps_pkg.
module eps_mult (
    input  logic [eps_pkg::MUL_W-1:0]  a,
    input  logic [eps_pkg::MUL_W-1:0]  b,
    output logic [eps_pkg::PROD_W-1:0] p
);
    import eps_pkg::*;

    // Full-width product; the caller registers it.
    assign p = PROD_W'(a) * PROD_W'(b);

endmodule

// File: src/eps_subcmp.sv
`timescale 1ns / 1ps
// Shared compare-and-subtract unit: one step of the square root and of the division.
// Depends on eps_pkg.
module eps_subcmp (
    input  logic [eps_pkg::REM_W-1:0] a,
    input  logic [eps_pkg::REM_W-1:0] b,
    output logic                      ge,
    output logic [eps_pkg::REM_W-1:0] diff
);
    import eps_pkg::*;

    logic [REM_W:0] wide;

    // The borrow out of one subtraction gives the comparison.
    assign wide = {1'b0, a} - {1'b0, b};
    assign ge   = ~wide[REM_W];
    assign diff = wide[REM_W-1:0];

endmodule

// File: src/eps_core.sv
`timescale 1ns / 1ps
// Sequencer and datapath of the envelope peak stretcher: magnitude, peak search,
// gain and the two divisions, plus the sample and magnitude history.
// Depends on eps_pkg, eps_mult and eps_subcmp.
module eps_core (
    input  logic                clk,
    input  logic                rst_n,
    input  eps_pkg::seq_ctrl_t  ctrl,
    input  eps_pkg::in_item_t   sample,
    output eps_pkg::seq_stat_t  stat,
    output eps_pkg::out_item_t  result
);
    import eps_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_SQ_I  = 11'b000_0000_0010,
        S_SQ_Q  = 11'b000_0000_0100,
        S_SUM   = 11'b000_0000_1000,
        S_ROOT  = 11'b000_0001_0000,
        S_PEAK  = 11'b000_0010_0000,
        S_GMUL  = 11'b000_0100_0000,
        S_GAIN  = 11'b000_1000_0000,
        S_DIV_I = 11'b001_0000_0000,
        S_DIV_Q = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // History: delayed samples (newest first) and past magnitudes (newest first).
    in_item_t         dly_reg [LOOKAHEAD];
    logic [SW-1:0]    hist_reg [HIST_LEN];

    // Working registers.
    in_item_t          new_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [SW-1:0]     root_reg;
    logic [SW-1:0]     peak_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [SW-1:0]     quot_reg;
    logic [SW-1:0]     dlo_reg;
    logic              neg_reg;
    cnt_t              cnt_reg;
    logic [SW-1:0]     res_i_reg;
    logic [SW-1:0]     res_q_reg;

    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [REM_W-1:0]  sc_a, sc_b, sc_diff;
    logic              sc_ge;
    logic              last_step;
    logic [SW-1:0]     peak_comb;
    logic [GAIN_W-1:0] g_val;
    logic [GAIN_W-1:0] gain_comb;
    logic [SW-1:0]     quot_comb;
    logic [SW-1:0]     signed_res;
    logic [ABS_W-1:0]  abs_i, abs_q;

    // Shared units.
    eps_mult u_mult (
        .a (mul_a),
        .b (mul_b),
        .p (mul_p)
    );

    eps_subcmp u_subcmp (
        .a    (sc_a),
        .b    (sc_b),
        .ge   (sc_ge),
        .diff (sc_diff)
    );

    // Multiplier operand selection: the two squares, then the peak times 2*emax.
    always_comb
    begin
        mul_a = MUL_W'(peak_reg);
        mul_b = TWO_EMAX_K;
        if (state_reg == S_SQ_I)
        begin
            mul_a = MUL_W'(abs_val(new_reg.in_i));
            mul_b = MUL_W'(abs_val(new_reg.in_i));
        end
        else if (state_reg == S_SQ_Q)
        begin
            mul_a = MUL_W'(abs_val(new_reg.in_q));
            mul_b = MUL_W'(abs_val(new_reg.in_q));
        end
    end

    // Compare-subtract operands: two radicand bits per root step, one dividend bit per
    // division step.
    always_comb
    begin
        if (state_reg == S_ROOT)
        begin
            sc_a = {rem_reg[REM_W-3:0], sum_reg[SUM_W-1 -: 2]};
            sc_b = {2'b00, root_reg, 2'b01};
        end
        else
        begin
            sc_a = {rem_reg[REM_W-2:0], dlo_reg[SW-1]};
            sc_b = REM_W'(gain_reg);
        end
    end

    assign last_step = (cnt_reg == cnt_t'(SW - 1));

    // Peak over the new magnitude and the stored ones.
    always_comb
    begin
        peak_comb = root_reg;
        for (int k = 0; k < HIST_LEN; k++)
        begin
            if (hist_reg[k] > peak_comb)
            begin
                peak_comb = hist_reg[k];
            end
        end
    end

    // Gain in Q4.12: 2*emax*peak less one, floored at one.
    assign g_val     = prod_reg[G_LSB + GAIN_W - 1 : G_LSB];
    assign gain_comb = (g_val >= GAIN_TWO) ? (g_val - GAIN_ONE) : GAIN_ONE;

    // Quotient after the current division step and its signed form.
    assign quot_comb  = {quot_reg[SW-2:0], sc_ge};
    assign signed_res = neg_reg ? (~quot_comb + 1'b1) : quot_comb;

    assign abs_i = abs_val(dly_reg[LOOKAHEAD-1].in_i);
    assign abs_q = abs_val(dly_reg[LOOKAHEAD-1].in_q);

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (ctrl.start) state_next = S_SQ_I;
            S_SQ_I:  state_next = S_SQ_Q;
            S_SQ_Q:  state_next = S_SUM;
            S_SUM:   state_next = S_ROOT;
            S_ROOT:  if (last_step) state_next = S_PEAK;
            S_PEAK:  state_next = S_GMUL;
            S_GMUL:  state_next = S_GAIN;
            S_GAIN:  state_next = S_DIV_I;
            S_DIV_I: if (last_step) state_next = S_DIV_Q;
            S_DIV_Q: if (last_step) state_next = S_DONE;
            S_DONE:  if (ctrl.ack) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // History is architectural state and resets to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LOOKAHEAD; k++)
            begin
                dly_reg[k] <= '0;
            end
            for (int k = 0; k < HIST_LEN; k++)
            begin
                hist_reg[k] <= '0;
            end
        end
        else if (state_reg == S_DONE && ctrl.ack)
        begin
            for (int k = LOOKAHEAD - 1; k > 0; k--)
            begin
                dly_reg[k] <= dly_reg[k-1];
            end
            dly_reg[0] <= new_reg;
            for (int k = HIST_LEN - 1; k > 0; k--)
            begin
                hist_reg[k] <= hist_reg[k-1];
            end
            hist_reg[0] <= root_reg;
        end
    end

    // Datapath registers stepped by the sequencer.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (ctrl.start)
                begin
                    new_reg <= sample;
                end
            end
            S_SQ_I:
            begin
                prod_reg <= mul_p;
            end
            S_SQ_Q:
            begin
                sum_reg  <= prod_reg[SUM_W-1:0];
                prod_reg <= mul_p;
            end
            S_SUM:
            begin
                sum_reg  <= sum_reg + prod_reg[SUM_W-1:0];
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            S_ROOT:
            begin
                sum_reg  <= {sum_reg[SUM_W-3:0], 2'b00};
                rem_reg  <= sc_ge ? sc_diff : sc_a;
                root_reg <= {root_reg[SW-2:0], sc_ge};
                cnt_reg  <= cnt_reg + 1'b1;
            end
            S_PEAK:
            begin
                peak_reg <= peak_comb;
            end
            S_GMUL:
            begin
                prod_reg <= mul_p;
            end
            S_GAIN:
            begin
                // Division of |I| * 4096; the upper quotient bits are known to be zero.
                gain_reg <= gain_comb;
                rem_reg  <= REM_W'(abs_i >> DIV_SHIFT);
                dlo_reg  <= {abs_i[DIV_SHIFT-1:0], GAIN_FRAC'(0)};
                neg_reg  <= dly_reg[LOOKAHEAD-1].in_i[SW-1];
                quot_reg <= '0;
                cnt_reg  <= '0;
            end
            S_DIV_I, S_DIV_Q:
            begin
                rem_reg  <= sc_ge ? sc_diff : sc_a;
                dlo_reg  <= {dlo_reg[SW-2:0], 1'b0};
                quot_reg <= quot_comb;
                cnt_reg  <= cnt_reg + 1'b1;
                if (last_step)
                begin
                    if (state_reg == S_DIV_I)
                    begin
                        // Same shared unit now takes the quadrature component.
                        res_i_reg <= signed_res;
                        rem_reg   <= REM_W'(abs_q >> DIV_SHIFT);
                        dlo_reg   <= {abs_q[DIV_SHIFT-1:0], GAIN_FRAC'(0)};
                        neg_reg   <= dly_reg[LOOKAHEAD-1].in_q[SW-1];
                        quot_reg  <= '0;
                    end
                    else
                    begin
                        res_q_reg <= signed_res;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign stat.busy    = (state_reg != S_IDLE);
    assign stat.done    = (state_reg == S_DONE);
    assign result.out_i = res_i_reg;
    assign result.out_q = res_q_reg;

endmodule

// File: src/envelope_peak_stretcher.sv
`timescale 1ns / 1ps
// Top level of the envelope peak stretcher: transaction handshakes and the output
// register around the sequenced core. Depends on eps_pkg and eps_core.
//
// Each input transaction carries one complex Q1.15 sample. The block returns the
// sample from two transactions earlier divided by the gain max(2*emax*peak - 1, 1),
// where peak is the largest magnitude over the five samples centred on it; the
// first two results after reset are zero. One transaction runs from acceptance until
// its result is loaded into the output register through the square root and the two
// divisions on one shared compare-subtract unit, plus the squares and the gain
// product on the shared multiplier. in_stall is high while the core works; a result
// waiting in the output register does not hold off the next input.
module envelope_peak_stretcher (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  eps_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output eps_pkg::out_item_t  out_data
);
    import eps_pkg::*;

    seq_ctrl_t ctrl;
    seq_stat_t stat;
    out_item_t core_result;
    logic      out_valid_reg;
    out_item_t out_data_reg;

    eps_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .sample (in_data),
        .stat   (stat),
        .result (core_result)
    );

    // Input is taken whenever the core is idle; the result moves out once the slot frees.
    assign in_stall   = stat.busy;
    assign ctrl.start = in_valid && !stat.busy;
    assign ctrl.ack   = stat.done && (!out_valid_reg || !out_stall);

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.ack)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ack)
        begin
            out_data_reg <= core_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // An accepted transaction keeps the core busy in the next cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |=> stat.busy)
        else $error("core not busy after accepting a transaction");

    // Handing over a result fills the output register and frees the core.
    a_ack_load: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ack |=> (out_valid && !stat.busy))
        else $error("result hand-over did not load output or free the core");

    // A finished result is held while the output register is blocked.
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.done && out_valid && out_stall) |=> stat.done)
        else $error("core dropped its result while the output was blocked");

endmodule

// File: tb/eps_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the envelope peak stretcher: watches both transaction channels,
// predicts every output from the accepted inputs and compares it field by field.
// Depends on eps_pkg for the transaction types and the datapath constants.
module eps_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  eps_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  eps_pkg::out_item_t out_data,
    output int                 failures,
    output int                 pending
);

    localparam int SW   = eps_pkg::SW;
    localparam int LA   = eps_pkg::LOOKAHEAD;
    localparam int HIST = eps_pkg::HIST_LEN;

    // Shadow state: delayed samples and past magnitudes, newest first.
    eps_pkg::in_item_t   delayed_samples [LA];
    logic [SW-1:0]       mag_hist [HIST];
    eps_pkg::out_item_t  expected_out [$];

    // Floor of the square root, one result bit per pair of input bits.
    function automatic logic [63:0] root_floor(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] probe;
        logic [63:0] rem;
        root  = 64'd0;
        rem   = n;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rem >= root + probe)
            begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Sample times one in Q4.12 over the gain, truncated toward zero.
    function automatic logic signed [SW-1:0] scale_down(input logic signed [SW-1:0] x,
                                                        input logic [15:0] gain);
        longint num;
        num = longint'(x) * longint'(eps_pkg::GAIN_ONE);
        return SW'(num / longint'(gain));
    endfunction

    // Advances the shadow state by one sample and queues the output it causes.
    task automatic envelope_step(input eps_pkg::in_item_t s);
        longint             ai;
        longint             aq;
        logic [63:0]        mag;
        logic [63:0]        peak;
        logic [63:0]        g;
        logic [15:0]        gain;
        eps_pkg::out_item_t r;
        ai = longint'(s.in_i);
        aq = longint'(s.in_q);
        if (ai < 0)
            ai = -ai;
        if (aq < 0)
            aq = -aq;
        mag  = root_floor(64'(ai * ai + aq * aq)) & ((64'd1 << SW) - 64'd1);
        peak = mag;
        for (int k = 0; k < HIST; k++)
        begin
            if (64'(mag_hist[k]) > peak)
                peak = 64'(mag_hist[k]);
        end
        // Twice emax times the peak in Q4.12; below two the gain is one.
        g = (peak * 64'(eps_pkg::TWO_EMAX_K)) >> eps_pkg::G_LSB;
        if (g >= 64'(eps_pkg::GAIN_TWO))
            gain = 16'(g - 64'(eps_pkg::GAIN_ONE));
        else
            gain = eps_pkg::GAIN_ONE;
        r.out_i = scale_down(delayed_samples[LA-1].in_i, gain);
        r.out_q = scale_down(delayed_samples[LA-1].in_q, gain);
        expected_out.push_back(r);
        for (int k = LA - 1; k > 0; k--)
            delayed_samples[k] = delayed_samples[k-1];
        delayed_samples[0] = s;
        for (int k = HIST - 1; k > 0; k--)
            mag_hist[k] = mag_hist[k-1];
        mag_hist[0] = SW'(mag);
    endtask

    // Outputs are checked before the new input is predicted, so that an unexpected
    // output can never be matched against a sample accepted at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LA; k++)
                delayed_samples[k] = '0;
            for (int k = 0; k < HIST; k++)
                mag_hist[k] = '0;
            expected_out.delete();
            failures = 0;
            pending  = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_out.size() == 0)
                begin
                    $error("unexpected output transaction: out_i %0d, out_q %0d",
                           out_data.out_i, out_data.out_q);
                    failures++;
                end
                else
                begin
                    if (out_data.out_i !== expected_out[0].out_i)
                    begin
                        $error("out_i: expected %0d, got %0d",
                               expected_out[0].out_i, out_data.out_i);
                        failures++;
                    end
                    if (out_data.out_q !== expected_out[0].out_q)
                    begin
                        $error("out_q: expected %0d, got %0d",
                               expected_out[0].out_q, out_data.out_q);
                        failures++;
                    end
                    void'(expected_out.pop_front());
                end
            end
            if (in_valid && !in_stall)
                envelope_step(in_data);
            pending = expected_out.size();
        end
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the envelope peak stretcher testbench: clock, reset, sample stimulus,
// output back-pressure and the final verdict. Depends on eps_pkg, the block and eps_checker.
module testbench;

    typedef enum int {
        MODE_FULL,
        MODE_QUIET,
        MODE_EDGE,
        MODE_EXTREME
    } stim_mode_t;

    localparam int RANDOM_ITEMS = 750;
    localparam int CALM_FROM    = 650;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    eps_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_stall;
    eps_pkg::out_item_t out_data;
    int                 failures;
    int                 pending;
    bit                 calm;

    envelope_peak_stretcher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    eps_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .failures  (failures),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #4000000;
        $display("envelope_peak_stretcher: mismatch");
        $finish;
    end

    // Offers one sample, sometimes after an idle burst, and returns once it is taken.
    task automatic send_sample(input logic signed [15:0] i_val,
                               input logic signed [15:0] q_val);
        eps_pkg::in_item_t s;
        s.in_i = i_val;
        s.in_q = q_val;
        if (!calm && $urandom_range(0, 2) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Picks one value of a sample component for the given envelope shape.
    function automatic logic signed [15:0] pick_component(input stim_mode_t mode);
        int v;
        case (mode)
            MODE_QUIET:
                v = $urandom_range(0, 22000) - 11000;
            MODE_EDGE:
                v = $urandom_range(11575, 11595);
            MODE_EXTREME:
            begin
                case ($urandom_range(0, 5))
                    0:       v = -32768;
                    1:       v = -32767;
                    2:       v = 32767;
                    3:       v = 1;
                    4:       v = -1;
                    default: v = 0;
                endcase
            end
            default:
                v = int'($urandom_range(0, 65535)) - 32768;
        endcase
        return 16'(v);
    endfunction

    // Receiver back-pressure: random stall bursts, sometimes a long clean stretch.
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 99) == 0)
            begin
                repeat (200) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Main stimulus: reset, directed samples, random envelopes, then the verdict.
    initial
    begin
        int                  dir_i [0:23];
        int                  dir_q [0:23];
        stim_mode_t          mode;
        int                  run_left;
        logic signed [15:0]  a;
        logic signed [15:0]  b;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        calm     = 1'b0;
        mode     = MODE_FULL;
        run_left = 0;
        // Start-up zeros, full-scale corners, the most negative sample, and the threshold
        // where the gain leaves one; the threshold samples are isolated by quiet samples.
        dir_i = '{0, 1, -1, 32767, -32768, -32768, 0, 32767, 0, 0, 0, 0,
                  11585, 0, 0, 0, 0, 11586, 0, 0, 0, 0, -32768, 5};
        dir_q = '{0, 0, -1, 32767, -32768, 0, -32768, -32768, 0, 0, 0, 0,
                  0, 0, 0, 0, 0, 0, 0, 0, 300, -300, 100, 0};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < 24; n++)
            send_sample(16'(dir_i[n]), 16'(dir_q[n]));

        // Random part: runs of one envelope shape so the peak window sees both
        // steady levels and sudden jumps.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == CALM_FROM)
                calm = 1'b1;
            if (run_left == 0)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: mode = MODE_FULL;
                    4, 5, 6:    mode = MODE_QUIET;
                    7, 8:       mode = MODE_EDGE;
                    default:    mode = MODE_EXTREME;
                endcase
                run_left = $urandom_range(1, 20);
            end
            run_left--;
            a = pick_component(mode);
            b = pick_component(mode);
            if (mode == MODE_EDGE)
            begin
                // Near the threshold only one component is large; signs vary.
                b = 16'($urandom_range(0, 6) - 3);
                if ($urandom_range(0, 1) == 1)
                    a = -a;
                if ($urandom_range(0, 1) == 1)
                begin
                    a = a ^ b;
                    b = a ^ b;
                    a = a ^ b;
                end
            end
            send_sample(a, b);
        end
        in_valid <= 1'b0;

        // Drain: wait for every predicted output, then let the pipeline settle.
        @(posedge clk);
        wait (pending == 0);
        repeat (100) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("envelope_peak_stretcher: match");
        else
            $display("envelope_peak_stretcher: mismatch");
        $finish;
    end

endmodule
